// ===== hw/rtl/phbm_pkg.sv =====
package phbm_pkg;

    // Field widths fixed by the item formats.
    localparam int unsigned COL_W   = 6;
    localparam int unsigned MAG_W   = 32;
    localparam int unsigned LVL_W   = 4;
    localparam int unsigned HOLD_W  = 8;
    localparam int unsigned BASE_W  = 32;
    localparam int unsigned STEP_W  = 28;

    // Thresholds reach at most base + 14 * step, which stays below 2^33.
    localparam int unsigned THR_W   = 33;

    // Column compare width, wide enough to hold a column count of 256.
    localparam int unsigned CCMP_W  = 9;

    // Configuration port.
    localparam int unsigned APB_AW  = 4;
    localparam int unsigned APB_DW  = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_STEP   = 2'd1;
    localparam logic [1:0] REG_RELOAD = 2'd2;

    // Register reset values.
    localparam logic [BASE_W-1:0] BASE_RST   = 32'd1024;
    localparam logic [STEP_W-1:0] STEP_RST   = 28'd4096;
    localparam logic [HOLD_W-1:0] RELOAD_RST = 8'd16;

    // Input item operation codes.
    localparam logic OP_BIN  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic             op;
        logic [COL_W-1:0] column;
        logic [MAG_W-1:0] magnitude;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] out_column;
        logic [LVL_W-1:0] bar_height;
        logic [LVL_W-1:0] peak_height;
    } t_out_item;

    // One column of meter state.
    typedef struct packed {
        logic [LVL_W-1:0]  peak;
        logic [HOLD_W-1:0] hold;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEVEL,
        ST_UPDATE,
        ST_DEC_RD,
        ST_DEC_WR
    } t_state;

endpackage

// ===== hw/rtl/peak_hold_bar_meter.sv =====
// Bar meter with peak hold. A bin word (op 0) names a column and a power
// magnitude and returns one result word with the bar height, the number of
// thresholds base + k*step (k = 0 .. LEVELS-1) that the magnitude strictly
// exceeds, and the column's held peak. A decay tick word (op 1) walks all
// columns and lowers each peak whose hold counter has run out; it returns no
// result. For a bin word one adder and comparator steps through the
// thresholds, one per cycle, then the column's entry is updated once the
// output register is free; a tick reads and then writes each column of the
// column memory in turn. The input is not ready while a word is being worked
// on. A finished result waits in an output register while the next word is
// taken in. Column state reads as zero after reset, so no clearing pass is
// needed. Configuration is an APB port with three registers: threshold base
// (0x0), threshold step (0x4) and hold reload (0x8).
module peak_hold_bar_meter #(
    parameter int unsigned COLUMNS = 64,
    parameter int unsigned LEVELS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  phbm_pkg::t_in_item            i_in,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output phbm_pkg::t_out_item           o_out,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [phbm_pkg::APB_AW-1:0]   paddr,
    input  logic [phbm_pkg::APB_DW-1:0]   pwdata,
    output logic [phbm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import phbm_pkg::*;

    localparam int unsigned IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Configuration registers.
    logic [BASE_W-1:0] r_base;
    logic [STEP_W-1:0] r_step;
    logic [HOLD_W-1:0] r_reload;

    // Sequencer and work registers.
    t_state            r_state;
    t_state            n_state;
    logic [COL_W-1:0]  r_col;
    logic [MAG_W-1:0]  r_mag;
    logic [THR_W-1:0]  r_thr;
    logic [LVL_W-1:0]  r_k;
    logic [LVL_W-1:0]  r_height;
    logic [IDX_W-1:0]  r_idx;

    // Column memory, its valid bits and the registered read port.
    t_entry            r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_valid;
    t_entry            r_rd_q;
    logic              r_vld_q;

    // Output register.
    logic              r_out_valid;
    t_out_item         r_out;

    // Control decoded from the state.
    logic              in_acc;
    logic              out_free;
    logic              cfg_wr;
    logic              rd_en;
    logic              wr_en;
    logic              load_out;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;

    // Datapath values.
    t_entry            cur;
    t_entry            upd;
    t_entry            dec;
    logic [HOLD_W-1:0] hold_dn;
    logic              in_range;
    logic              last_lvl;
    logic              last_col;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign last_lvl = (r_k == LVL_W'(LEVELS - 1));
    assign last_col = (r_idx == IDX_W'(COLUMNS - 1));
    assign in_range = ({3'b000, r_col} < CCMP_W'(COLUMNS));

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_RST;
            r_step   <= STEP_RST;
            r_reload <= RELOAD_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BASE:   r_base   <= pwdata[BASE_W-1:0];
                REG_STEP:   r_step   <= pwdata[STEP_W-1:0];
                REG_RELOAD: r_reload <= pwdata[HOLD_W-1:0];
                default:    ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        case (paddr[3:2])
            REG_BASE:   prdata = r_base;
            REG_STEP:   prdata = {{(APB_DW - STEP_W){1'b0}}, r_step};
            REG_RELOAD: prdata = {{(APB_DW - HOLD_W){1'b0}}, r_reload};
            default:    prdata = '0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.op == OP_TICK) ? ST_DEC_RD : ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                if (last_lvl) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DEC_RD: n_state = ST_DEC_WR;
            ST_DEC_WR: begin
                n_state = last_col ? ST_IDLE : ST_DEC_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        load_out   = 1'b0;
        rd_addr    = r_idx;
        wr_addr    = r_idx;
        wr_data    = dec;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                rd_en      = in_acc && (i_in.op == OP_BIN);
                rd_addr    = IDX_W'({3'b000, i_in.column});
            end
            ST_UPDATE: begin
                load_out = out_free;
                wr_en    = out_free && in_range;
                wr_addr  = IDX_W'({3'b000, r_col});
                wr_data  = upd;
            end
            ST_DEC_RD: rd_en = 1'b1;
            ST_DEC_WR: wr_en = 1'b1;
            default: ;
        endcase
    end

    // An entry never written reads as zero.
    assign cur     = r_vld_q ? r_rd_q : '0;
    assign hold_dn = (cur.hold != '0) ? cur.hold - 1'b1 : cur.hold;

    // Bin update: a higher bar becomes the new peak and reloads the hold; else the hold counts down.
    always_comb begin
        if (r_height > cur.peak) begin
            upd.peak = r_height;
            upd.hold = r_reload;
        end else begin
            upd.peak = cur.peak;
            upd.hold = hold_dn;
        end
    end

    // Decay: a peak whose hold has run out drops by one, stopping at zero.
    always_comb begin
        dec = cur;
        if (cur.hold == '0 && cur.peak != '0) begin
            dec.peak = cur.peak - 1'b1;
        end
    end

    // Sequencer state and the threshold walk on the shared adder and compare.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_col    <= i_in.column;
                r_mag    <= i_in.magnitude;
                r_thr    <= {1'b0, r_base};
                r_k      <= '0;
                r_height <= '0;
                r_idx    <= '0;
            end
            ST_LEVEL: begin
                if ({1'b0, r_mag} > r_thr) begin
                    r_height <= r_height + 1'b1;
                end
                r_thr <= r_thr + {{(THR_W - STEP_W){1'b0}}, r_step};
                r_k   <= r_k + 1'b1;
            end
            ST_DEC_WR: begin
                r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    // Column memory: one read and one write port, registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_q <= r_mem[rd_addr];
        end
    end

    // Valid bits stand in for clearing the memory at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_q <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_vld_q <= r_valid[rd_addr];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.out_column  <= r_col;
            r_out.bar_height  <= r_height;
            r_out.peak_height <= in_range ? upd.peak : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A result never shows a bar above the top row.
    a_bar_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.bar_height <= LVL_W'(LEVELS))
        else $error("bar height above the number of rows");

    // The held peak of a real column is never below the bar just reported.
    a_peak_ge_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ({3'b000, o_out.out_column} < CCMP_W'(COLUMNS))
        |-> o_out.peak_height >= o_out.bar_height)
        else $error("peak below bar height");

    // A tick word starts the decay sweep at the first column.
    a_tick_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in.op == OP_TICK) |=> r_state == ST_DEC_RD && r_idx == '0)
        else $error("decay sweep did not start");

    // A result is only loaded into a free output register.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result overwrote a pending result");

    // The threshold walk never runs past the last level.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LEVEL |-> r_k <= LVL_W'(LEVELS - 1))
        else $error("threshold walk overran");

endmodule
